// ----- rtl/prpu_pkg.sv -----
`default_nettype none

package prpu_pkg;

    localparam int WORD_W    = 16;
    localparam int PIX14_W   = 14;
    localparam int PIX_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_ADJ   = 2'd3;

    localparam logic [WORD_W-1:0] BLACK_RESET  = 16'd2000;
    localparam logic [PIX_W-1:0]  BLACK_OFFSET = 17'd15;

    typedef struct packed {
        logic [WORD_W-1:0] black_level;
        logic              swap_bytes;
        logic              plain_16bit_mode;
        logic              black_adjust_on;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             masked;
        logic             last;
    } pixel_t;

endpackage

`default_nettype wire

// ----- rtl/prpu_unpack.sv -----
`default_nettype none

module prpu_unpack (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [prpu_pkg::WORD_W-1:0]   word_in,
    input  wire logic                          frame_start,
    input  wire prpu_pkg::cfg_t                cfg,
    output prpu_pkg::pixel_t                   pix0,
    output prpu_pkg::pixel_t                   pix1,
    output logic                               two_pix
);

    // only the spare bits are kept; the low 16 bits of the accumulator are always zero
    logic [prpu_pkg::PIX14_W-1:0] acc_reg, acc_next;
    logic [3:0]                   spare_reg, spare_next;
    logic [prpu_pkg::PIX_W-1:0]   hist0_reg, hist0_next;
    logic [prpu_pkg::PIX_W-1:0]   hist1_reg, hist1_next;

    logic [prpu_pkg::PIX14_W-1:0] acc_eff;
    logic [3:0]                   spare_eff;
    logic [prpu_pkg::PIX_W-1:0]   h0_eff, h1_eff;
    logic [prpu_pkg::WORD_W-1:0]  word_sw;
    logic [4:0]                   sb_sum;
    logic [3:0]                   sb;
    logic [29:0]                  acc_or;
    logic [29:0]                  acc_sh;
    logic [prpu_pkg::PIX14_W-1:0] keep_mask;
    logic [prpu_pkg::WORD_W-1:0]  raw0, raw1;
    logic                         masked0, masked1;
    logic [prpu_pkg::PIX_W-1:0]   val0, val1;

    function automatic logic [prpu_pkg::PIX_W-1:0] adjust(
        input logic [prpu_pkg::WORD_W-1:0] raw,
        input logic [prpu_pkg::WORD_W-1:0] black,
        input logic                        adj_on
    );
        logic [prpu_pkg::PIX_W-1:0] res;
        if (!adj_on)
            res = {1'b0, raw};
        else if (raw > black)
            res = {1'b0, raw} - {1'b0, black} + prpu_pkg::BLACK_OFFSET;
        else
            res = prpu_pkg::BLACK_OFFSET;
        return res;
    endfunction

    always_comb
    begin
        acc_eff   = frame_start ? '0 : acc_reg;
        spare_eff = frame_start ? '0 : spare_reg;
        h0_eff    = frame_start ? '0 : hist0_reg;
        h1_eff    = frame_start ? '0 : hist1_reg;

        word_sw = cfg.swap_bytes ? {word_in[7:0], word_in[15:8]} : word_in;

        sb_sum    = {1'b0, spare_eff} + 5'd2;
        sb        = (sb_sum > 5'd14) ? 4'd14 : sb_sum[3:0];
        acc_or    = {acc_eff, word_sw};
        acc_sh    = acc_or >> sb;
        keep_mask = ~(14'h3FFF << sb);

        raw0    = cfg.plain_16bit_mode ? word_sw : {2'b00, acc_sh[13:0]};
        raw1    = {2'b00, word_sw[13:0]};
        two_pix = !cfg.plain_16bit_mode && (sb == 4'd14);

        masked0 = (raw0 == '0);
        val0    = masked0 ? h1_eff
                          : adjust(raw0, cfg.black_level, cfg.black_adjust_on);
        // second pixel: history has shifted once, so two places back is the old last pixel
        masked1 = (raw1 == '0);
        val1    = masked1 ? h0_eff
                          : adjust(raw1, cfg.black_level, cfg.black_adjust_on);

        if (cfg.plain_16bit_mode)
        begin
            acc_next   = acc_eff;
            spare_next = spare_eff;
        end
        else if (two_pix)
        begin
            acc_next   = '0;
            spare_next = '0;
        end
        else
        begin
            acc_next   = word_sw[13:0] & keep_mask;
            spare_next = sb;
        end

        if (two_pix)
        begin
            hist0_next = val1;
            hist1_next = val0;
        end
        else
        begin
            hist0_next = val0;
            hist1_next = h0_eff;
        end

        pix0.value  = val0;
        pix0.masked = masked0;
        pix0.last   = !two_pix;
        pix1.value  = val1;
        pix1.masked = masked1;
        pix1.last   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            spare_reg <= '0;
            hist0_reg <= '0;
            hist1_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            spare_reg <= spare_next;
            hist0_reg <= hist0_next;
            hist1_reg <= hist1_next;
        end
    end

    a_spare_even : assert property (@(posedge clk) disable iff (!rst_n)
        (spare_reg[0] == 1'b0) && (spare_reg <= 4'd12))
        else $error("spare bit count left the packing cycle");

    a_acc_fits : assert property (@(posedge clk) disable iff (!rst_n)
        ((acc_reg >> spare_reg) == '0))
        else $error("accumulator holds bits above spare count");

    a_two_after_group : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && two_pix) |=> (spare_reg == '0) && (acc_reg == '0))
        else $error("group end did not clear accumulator");

endmodule

`default_nettype wire

// ----- rtl/prpu_fifo.sv -----
`default_nettype none

module prpu_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push0,
    input  wire logic              push1,
    input  wire prpu_pkg::pixel_t  din0,
    input  wire prpu_pkg::pixel_t  din1,
    input  wire logic              pop,
    output prpu_pkg::pixel_t       dout,
    output logic                   not_empty,
    output logic                   room2
);

    prpu_pkg::pixel_t                mem_reg [prpu_pkg::FIFO_DEPTH];
    logic [prpu_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [prpu_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [prpu_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [prpu_pkg::FIFO_PTR_W-1:0] wr_ptr_p1;
    logic [prpu_pkg::FIFO_CNT_W-1:0] n_push;
    logic [prpu_pkg::FIFO_CNT_W-1:0] count_after_pop;

    always_comb
    begin
        not_empty       = (count_reg != '0);
        dout            = mem_reg[rd_ptr_reg];
        count_after_pop = count_reg - {{(prpu_pkg::FIFO_CNT_W-1){1'b0}}, pop};
        room2           = (count_after_pop
                           <= prpu_pkg::FIFO_CNT_W'(prpu_pkg::FIFO_DEPTH - 2));
        wr_ptr_p1       = wr_ptr_reg + 1'b1;
        n_push          = {{(prpu_pkg::FIFO_CNT_W-1){1'b0}}, push0}
                        + {{(prpu_pkg::FIFO_CNT_W-1){1'b0}}, push1};
        wr_ptr_next     = wr_ptr_reg + n_push[prpu_pkg::FIFO_PTR_W-1:0];
        rd_ptr_next     = rd_ptr_reg + {{(prpu_pkg::FIFO_PTR_W-1){1'b0}}, pop};
        count_next      = count_after_pop + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wr_ptr_reg] <= din0;
        if (push1)
            mem_reg[wr_ptr_p1] <= din1;
    end

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= prpu_pkg::FIFO_CNT_W'(prpu_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_push_order : assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> (push0 && room2))
        else $error("second push without first or without room");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty result queue");

endmodule

`default_nettype wire

// ----- rtl/packed_raw_pixel_unpacker_top.sv -----
`default_nettype none

// Raw sensor word unpacker. Each accepted 16-bit word (optionally byte swapped)
// is held in an input register, then unpacked, dead-pixel patched and black
// adjusted in a single pass into a four-entry result queue. A word is accepted
// every cycle while the queue can take two pixels; results leave at one pixel
// per cycle while out_stall is low, so in packed 14-bit mode seven words give
// eight pixels and the sustained input rate is set by the result port (one
// word per cycle in plain 16-bit mode). The first pixel of a word is offered
// on the result port once the word has passed the input register into the
// result queue. frame_start clears the bit accumulator and pixel history
// before its word is used. Configuration writes are always ready and take
// effect on words processed after the write.

module packed_raw_pixel_unpacker_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [prpu_pkg::WORD_W-1:0]       data_word,
    input  wire logic                              frame_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [prpu_pkg::PIX_W-1:0]             pixel_value,
    output logic                                   pixel_was_masked,
    output logic                                   last_of_word,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [prpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [prpu_pkg::WORD_W-1:0]       cfg_data
);

    prpu_pkg::cfg_t              cfg_reg;
    logic                        s1_valid_reg;
    logic [prpu_pkg::WORD_W-1:0] s1_word_reg;
    logic                        s1_fs_reg;
    logic                        in_xfer;
    logic                        advance;
    logic                        room2;
    logic                        two_pix;
    logic                        pop;
    prpu_pkg::pixel_t            pix0, pix1, q_out;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && room2;
    assign in_stall  = s1_valid_reg && !room2;
    assign in_xfer   = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_level      <= prpu_pkg::BLACK_RESET;
            cfg_reg.swap_bytes       <= 1'b0;
            cfg_reg.plain_16bit_mode <= 1'b0;
            cfg_reg.black_adjust_on  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prpu_pkg::CFG_BLACK_LEVEL: cfg_reg.black_level      <= cfg_data;
                prpu_pkg::CFG_SWAP_BYTES:  cfg_reg.swap_bytes       <= cfg_data[0];
                prpu_pkg::CFG_PLAIN_MODE:  cfg_reg.plain_16bit_mode <= cfg_data[0];
                prpu_pkg::CFG_BLACK_ADJ:   cfg_reg.black_adjust_on  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_xfer)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_word_reg <= data_word;
            s1_fs_reg   <= frame_start;
        end
    end

    prpu_unpack u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .word_in     (s1_word_reg),
        .frame_start (s1_fs_reg),
        .cfg         (cfg_reg),
        .pix0        (pix0),
        .pix1        (pix1),
        .two_pix     (two_pix)
    );

    prpu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (advance),
        .push1     (advance && two_pix),
        .din0      (pix0),
        .din1      (pix1),
        .pop       (pop),
        .dout      (q_out),
        .not_empty (out_valid),
        .room2     (room2)
    );

    assign pixel_value      = q_out.value;
    assign pixel_was_masked = q_out.masked;
    assign last_of_word     = q_out.last;

endmodule

`default_nettype wire
